@@ rtl/mper_pkg.sv @@
package mper_pkg;

  // Fixed register layout of the rule table
  localparam int BYTE_W     = 8;
  localparam int REG_W      = 59;
  localparam int NUM_RULES  = 4;
  localparam int LEN_W      = 3;
  localparam int LEN_LSB    = 56;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // append the accepted byte to the window
    logic step;   // advance one position or one replacement byte
    logic done;   // all results of the current item are decided
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic can_step;     // output staging has room, or no byte is due
    logic last_piece;   // this step finishes the head position
    logic empty_after;  // window is empty once the head is dropped
    logic fill_now;     // one more byte fills the window
  } stat_t;

  // Clamp a length field to a cap
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw,
                                                 input logic [LEN_W-1:0] cap);
    return (raw > cap) ? cap : raw;
  endfunction

endpackage

@@ rtl/mper_ctrl.sv @@
module mper_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           s_tlast,
  input  mper_pkg::stat_t stat,
  output mper_pkg::cmd_t  cmd
);
  import mper_pkg::*;

  state_t state, state_next;
  logic   flush;

  // State register and chunk-end flag of the item in work
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      flush <= 1'b0;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) flush <= s_tlast;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast || stat.fill_now) begin
            state_next = ST_RUN;
          end else begin
            cmd.done = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (stat.can_step) begin
          cmd.step = 1'b1;
          // a chunk end drains the window, otherwise one position is decided
          if (stat.last_piece && (!flush || stat.empty_after)) begin
            cmd.done   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/mper_dp.sv @@
module mper_dp #(
  parameter int MAX_RULES             = 4,
  parameter int MAX_PATTERN_BYTES     = 7,
  parameter int MAX_REPLACEMENT_BYTES = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mper_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mper_pkg::REG_W-1:0]      cfg_data,
  input  logic [mper_pkg::BYTE_W-1:0]     in_byte,
  input  mper_pkg::cmd_t                  cmd,
  output mper_pkg::stat_t                 stat,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mper_pkg::BYTE_W-1:0]     m_tdata,
  output logic                            m_tlast
);
  import mper_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [BYTE_W-1:0] win [MAX_PATTERN_BYTES];
  logic [CNT_W-1:0]  count;
  logic [REG_W-1:0]  pat [NUM_RULES];
  logic [REG_W-1:0]  rep [NUM_RULES];
  logic [LEN_W-1:0]  k;

  logic              pend_valid;
  logic              pend_final;
  logic [BYTE_W-1:0] pend_byte;

  logic              hit;
  logic [LEN_W-1:0]  hit_plen;
  logic [REG_W-1:0]  hit_rep;
  logic [LEN_W-1:0]  rlen;
  logic              need_emit;
  logic              emit_now;
  logic              emit_ok;
  logic              out_free;
  logic              move;
  logic              last_piece;
  logic [LEN_W-1:0]  consumed;
  logic [CNT_W-1:0]  cnt_after;
  logic [BYTE_W-1:0] emit_byte;

  // Rule table write port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_RULES; r++) begin
        pat[r] <= '0;
        rep[r] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_addr[0]) rep[cfg_addr[CFG_ADDR_W-1:1]] <= cfg_data;
      else             pat[cfg_addr[CFG_ADDR_W-1:1]] <= cfg_data;
    end
  end

  // First rule in table order that fits and matches at the window head
  always_comb begin
    logic [LEN_W-1:0] plen_r;
    logic             live;
    logic             eq;
    hit      = 1'b0;
    hit_plen = '0;
    hit_rep  = '0;
    live     = 1'b1;
    for (int r = 0; r < MAX_RULES; r++) begin
      plen_r = clamp_len(pat[r][LEN_LSB +: LEN_W], LEN_W'(MAX_PATTERN_BYTES));
      if (plen_r == '0) live = 1'b0;
      eq = live && (CMP_W'(plen_r) <= CMP_W'(count));
      for (int b = 0; b < MAX_PATTERN_BYTES; b++) begin
        if ((LEN_W'(b) < plen_r) && (win[b] != pat[r][BYTE_W*b +: BYTE_W])) eq = 1'b0;
      end
      if (eq && !hit) begin
        hit      = 1'b1;
        hit_plen = plen_r;
        hit_rep  = rep[r];
      end
    end
  end

  // Byte due at this step and amount to drop from the window
  assign rlen       = clamp_len(hit_rep[LEN_LSB +: LEN_W], LEN_W'(MAX_REPLACEMENT_BYTES));
  assign need_emit  = !hit || (rlen != '0);
  assign emit_byte  = hit ? hit_rep[{k, 3'b000} +: BYTE_W] : win[0];
  assign last_piece = !hit || (rlen == '0) || (k == rlen - 1'b1);
  assign consumed   = hit ? hit_plen : LEN_W'(1);
  assign cnt_after  = count - CNT_W'(consumed);

  // Output staging: a byte waits in pend until the next byte or the item end
  assign out_free = !m_tvalid || m_tready;
  assign emit_ok  = !pend_valid || out_free;
  assign emit_now = cmd.step && need_emit;
  assign move     = pend_valid && out_free && (pend_final || emit_now);

  assign stat.can_step    = !need_emit || emit_ok;
  assign stat.last_piece  = last_piece;
  assign stat.empty_after = (cnt_after == '0);
  assign stat.fill_now    = (count == CNT_W'(MAX_PATTERN_BYTES - 1));

  // Window: append on load, drop the decided head on the last piece
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        if (count == CNT_W'(i)) win[i] <= in_byte;
      end
    end else if (cmd.step && last_piece) begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        for (int s = 1; s < MAX_PATTERN_BYTES - i; s++) begin
          if (consumed == LEN_W'(s)) win[i] <= win[i+s];
        end
      end
    end
  end

  // Fill count and replacement byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      k     <= '0;
    end else begin
      if (cmd.load) count <= count + 1'b1;
      else if (cmd.step && last_piece) count <= cnt_after;
      if (cmd.step) k <= last_piece ? '0 : k + 1'b1;
    end
  end

  // Pending byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_final <= 1'b0;
    end else if (emit_now) begin
      pend_valid <= 1'b1;
      pend_final <= cmd.done;
    end else begin
      if (move) pend_valid <= 1'b0;
      if (cmd.done) pend_final <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) pend_byte <= emit_byte;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_tdata <= pend_byte;
      m_tlast <= pend_final;
    end
  end

endmodule

@@ rtl/multi_pattern_escape_replacer_core.sv @@
// Escaping byte stream filter with a four-rule search and replace table.
// Input stream: s_tdata carries one raw byte, s_tlast marks the last byte of a
// chunk; an item is taken when s_tvalid and s_tready are high at a clock edge.
// Output stream: m_tdata carries one escaped byte, m_tlast marks the final
// byte caused by one input item.
// Rules are loaded through cfg_we/cfg_addr/cfg_data (even address: pattern,
// odd address: replacement of rule addr/2) while the stream is idle.
// Bytes are held in a lookahead window of MAX_PATTERN_BYTES entries; a
// position is decided when the window fills, and at a chunk end the window is
// drained. An item is accepted in the idle state; each decided position then
// takes one step per replacement byte (one for a pass-through byte, one for an
// empty replacement), as the datapath emits a single output byte per cycle
// while the output is not stalled. The next item is taken once the previous
// one is decided. The final byte of an item passes through the staging byte
// and then the output register after its decision.
// Reset clears the rule table, empties the window and drops pending output.
// When the receiver stalls, the output register and one staging byte hold
// and the controller waits, backing up into s_tready.
module multi_pattern_escape_replacer_core #(
  parameter int MAX_RULES             = 4,
  parameter int MAX_PATTERN_BYTES     = 7,
  parameter int MAX_REPLACEMENT_BYTES = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mper_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mper_pkg::REG_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic                            s_tlast,   // chunk_end
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] out_byte
  output logic                            m_tlast    // last_of_run
);
  import mper_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mper_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  mper_dp #(
    .MAX_RULES             (MAX_RULES),
    .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
    .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_byte  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ bench/tb_multi_pattern_escape_replacer_core.sv @@
`timescale 1ns / 100ps

module tb_multi_pattern_escape_replacer_core;
  import mper_pkg::*;

  localparam int WIN_DEPTH   = 7;
  localparam int MAX_REP     = 7;
  localparam int IDLE_PCT    = 11;
  localparam int QUIET       = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 200000;

  // Rule table register map: pattern and replacement of each rule
  typedef enum logic [CFG_ADDR_W-1:0] {
    R0_PAT, R0_REP, R1_PAT, R1_REP, R2_PAT, R2_REP, R3_PAT, R3_REP
  } rule_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } esc_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  m_tlast;

  // Shadow of the rule table and of the lookahead window
  logic [REG_W-1:0] rule_regs [8];
  logic [7:0]       held_bytes [WIN_DEPTH];
  int               held_cnt = 0;

  raw_item_t   pend_items [$];
  esc_out_t    escaped_due [$];
  raw_item_t   next_item;
  int unsigned items_taken = 0;
  int unsigned fail_cnt = 0;
  int unsigned cyc = 0;
  bit          feed_hold = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned hold_trig = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic [7:0]  alpha [4];

  multi_pattern_escape_replacer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rule_reg_t pat_reg(int r);
    case (r)
      0: return R0_PAT;
      1: return R1_PAT;
      2: return R2_PAT;
      default: return R3_PAT;
    endcase
  endfunction

  function automatic rule_reg_t rep_reg(int r);
    case (r)
      0: return R0_REP;
      1: return R1_REP;
      2: return R2_REP;
      default: return R3_REP;
    endcase
  endfunction

  function automatic int len_of(logic [REG_W-1:0] v, int cap);
    int n;
    n = int'(v[LEN_LSB +: LEN_W]);
    return (n > cap) ? cap : n;
  endfunction

  // First rule whose whole pattern sits at the window head; -1 if none
  function automatic int match_rule();
    logic [REG_W-1:0] p;
    int plen;
    bit hit;
    for (int r = 0; r < NUM_RULES; r++) begin
      p = rule_regs[pat_reg(r)];
      plen = len_of(p, WIN_DEPTH);
      if (plen == 0) return -1;
      if (plen <= held_cnt) begin
        hit = 1'b1;
        for (int k = 0; k < plen; k++)
          if (held_bytes[k] != p[8*k +: 8]) hit = 1'b0;
        if (hit) return r;
      end
    end
    return -1;
  endfunction

  // Append one byte, decide positions and queue the escaped bytes it causes
  task automatic escape_item(logic [7:0] b, logic ce);
    esc_out_t run [$];
    esc_out_t o;
    logic [REG_W-1:0] rep;
    int r;
    int used;
    if (held_cnt < WIN_DEPTH) begin
      held_bytes[held_cnt] = b;
      held_cnt++;
    end
    while (held_cnt > 0 && (ce || held_cnt >= WIN_DEPTH)) begin
      r = match_rule();
      o.last_of_run = 1'b0;
      if (r < 0) begin
        o.out_byte = held_bytes[0];
        run.push_back(o);
        used = 1;
      end else begin
        rep = rule_regs[rep_reg(r)];
        for (int k = 0; k < len_of(rep, MAX_REP); k++) begin
          o.out_byte = rep[8*k +: 8];
          run.push_back(o);
        end
        used = len_of(rule_regs[pat_reg(r)], WIN_DEPTH);
      end
      for (int k = 0; k < held_cnt - used; k++)
        held_bytes[k] = held_bytes[k + used];
      held_cnt -= used;
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) escaped_due.push_back(run[i]);
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_escaped(logic [7:0] b, logic last);
    esc_out_t want;
    if (escaped_due.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h last %0b", b, last));
      return;
    end
    want = escaped_due.pop_front();
    if (b !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, want %02h", b, want.out_byte));
    if (last !== want.last_of_run)
      report_mismatch($sformatf("last_of_run %0b, want %0b on byte %02h",
                                last, want.last_of_run, want.out_byte));
  endtask

  // Input driver: predict on acceptance, then offer the next pending item
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        escape_item(s_tdata, s_tlast);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pend_items.size() > 0 && !feed_hold &&
            (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          next_item = pend_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_item.data_byte;
          s_tlast  <= next_item.chunk_end;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each accepted byte, stall at random or on hold
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_escaped(m_tdata, m_tlast);
      if (hold_left > 0)
        m_tready <= 1'b0;
      else
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Long receiver hold-off, started by a bump of hold_trig
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_seen != hold_trig) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Cycle limit
  initial begin
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic write_reg(rule_reg_t idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    rule_regs[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [REG_W-1:0] rand_reg(int len);
    logic [REG_W-1:0] v;
    v = REG_W'({$urandom, $urandom});
    v[LEN_LSB +: LEN_W] = LEN_W'(len);
    return v;
  endfunction

  task automatic load_all(logic [REG_W-1:0] val);
    for (int r = 0; r < NUM_RULES; r++) begin
      write_reg(pat_reg(r), val);
      write_reg(rep_reg(r), val);
    end
  endtask

  // Random table: mostly short patterns over a small alphabet so that they hit
  task automatic load_random_table();
    logic [REG_W-1:0] p;
    int plen;
    int pick;
    for (int r = 0; r < NUM_RULES; r++) begin
      pick = $urandom_range(7);
      plen = (pick == 0) ? 0 : (pick == 1) ? WIN_DEPTH : $urandom_range(3, 1);
      p = rand_reg(plen);
      for (int k = 0; k < plen; k++) p[8*k +: 8] = alpha[$urandom_range(3)];
      write_reg(pat_reg(r), p);
      write_reg(rep_reg(r), rand_reg($urandom_range(MAX_REP)));
    end
  endtask

  task automatic queue_item(logic [7:0] b, logic ce);
    raw_item_t it;
    it.data_byte = b;
    it.chunk_end = ce;
    pend_items.push_back(it);
  endtask

  task automatic queue_byte(logic [7:0] b);
    queue_item(b, $urandom_range(99) < 12);
  endtask

  // Mostly whole patterns and alphabet bytes, some arbitrary bytes
  task automatic push_random(int n);
    logic [REG_W-1:0] p;
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 35) begin
        p = rule_regs[pat_reg($urandom_range(NUM_RULES - 1))];
        for (int k = 0; k < len_of(p, WIN_DEPTH); k++) begin
          queue_byte(p[8*k +: 8]);
          cnt++;
        end
        if (len_of(p, WIN_DEPTH) == 0) begin
          queue_byte(8'($urandom_range(255)));
          cnt++;
        end
      end else begin
        queue_byte(($urandom_range(99) < 80) ? alpha[$urandom_range(3)]
                                             : 8'($urandom_range(255)));
        cnt++;
      end
    end
  endtask

  // Wait until nothing is in flight, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pend_items.size() != 0 || s_tvalid || escaped_due.size() != 0);
    repeat (QUIET) @(posedge clk);
  endtask

  initial begin
    logic [REG_W-1:0] v;
    int unsigned mark;
    foreach (rule_regs[i]) rule_regs[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty table: pass-through, window fill, single-byte chunk
    @(negedge clk);
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    for (int k = 0; k < 5; k++) queue_item(8'h55 ^ 8'(k), 1'b0);
    queue_item(8'hAA, 1'b1);
    queue_item(8'h5A, 1'b1);
    wait_idle();

    // Escape rule, empty replacement, full replacement, table end at rule 3
    v = rand_reg(1); v[7:0] = 8'h5C;
    write_reg(R0_PAT, v);
    v = rand_reg(2); v[15:0] = 16'h5C5C;
    write_reg(R0_REP, v);
    v = '1;
    write_reg(R1_PAT, v);
    write_reg(R1_REP, rand_reg(0));
    v = rand_reg(2); v[15:0] = 16'h0100;
    write_reg(R2_PAT, v);
    write_reg(R2_REP, '1);
    v = '1; v[LEN_LSB +: LEN_W] = '0;
    write_reg(R3_PAT, v);
    write_reg(R3_REP, rand_reg(3));
    @(negedge clk);
    queue_item(8'h5C, 1'b1);
    for (int k = 0; k < WIN_DEPTH; k++) queue_item(8'hFF, 1'b0);
    queue_item(8'h00, 1'b0);
    queue_item(8'h01, 1'b1);
    // pattern too long for what is left of the chunk
    queue_item(8'h00, 1'b1);
    queue_item(8'hFF, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'hFF, 1'b1);
    // leave bytes held across the next table change
    queue_item(8'h5C, 1'b0);
    queue_item(8'h5C, 1'b0);
    wait_idle();

    // Random phases under several tables
    for (int ph = 0; ph < 6; ph++) begin
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(255));
      case (ph)
        0: load_all('1);
        1: load_all('0);
        default: load_random_table();
      endcase
      @(negedge clk);
      no_idle = (ph == 4);
      mark = items_taken;
      push_random(20);
      if (ph == 2) hold_trig = hold_trig + 1;
      if (ph == 3) begin
        while (items_taken < mark + 12) @(negedge clk);
        feed_hold = 1'b1;
        do @(negedge clk);
        while (s_tvalid || escaped_due.size() != 0);
        feed_hold = 1'b0;
      end
      wait_idle();
      no_idle = 1'b0;
    end

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
